>>> rtl/aat_pkg.sv
// ----------------------------------------------------------------------------
// aat_pkg
// Shared constants for the box affine transform: default widths, register
// map codes and box kind codes.
// ----------------------------------------------------------------------------
package aat_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int COEF_WIDTH_DEF  = 16;

    localparam int KIND_WIDTH = 2;

    // APB port: 64-bit data, registers at 8-byte spacing
    localparam int APB_ADDR_WIDTH = 6;
    localparam int APB_DATA_WIDTH = 64;
    localparam int REG_IDX_WIDTH  = 3;
    localparam int REG_IDX_LSB    = 3;

    localparam logic [REG_IDX_WIDTH-1:0] REG_ROW0  = 3'd0;
    localparam logic [REG_IDX_WIDTH-1:0] REG_ROW1  = 3'd1;
    localparam logic [REG_IDX_WIDTH-1:0] REG_ROW2  = 3'd2;
    localparam logic [REG_IDX_WIDTH-1:0] REG_TRANS_X = 3'd3;
    localparam logic [REG_IDX_WIDTH-1:0] REG_TRANS_Y = 3'd4;
    localparam logic [REG_IDX_WIDTH-1:0] REG_TRANS_Z = 3'd5;

    localparam logic [KIND_WIDTH-1:0] KIND_NULL     = 2'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_FINITE   = 2'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_INFINITE = 2'd2;

endpackage

>>> rtl/aabb_affine_transform.sv
// ----------------------------------------------------------------------------
// aabb_affine_transform
// Transforms a finite axis-aligned box by a 3x3 Q2.14 matrix plus a Q16.16
// translation (center through M, half size through |M|); all other kinds
// (null, infinite and the unassigned code) pass through unchanged.
// Stages: input register, product register, result register; each stage
// holds its item while the stage after it is full and cannot pass its own on.
// Throughput: one item per cycle while out_ready is high; all eighteen
// coefficient multiplies are done in parallel, so nothing iterates.
// Reset: clears all stage valid bits and loads the identity matrix and a
// zero translation; corner and product registers are not reset.
// ----------------------------------------------------------------------------
module aabb_affine_transform
    import aat_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = COEF_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_WIDTH-1:0]     paddr,
    input  logic [APB_DATA_WIDTH-1:0]     pwdata,
    output logic [APB_DATA_WIDTH-1:0]     prdata,
    output logic                          pready,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [KIND_WIDTH-1:0]         extent_kind,
    input  logic signed [COORD_WIDTH-1:0] low_x,
    input  logic signed [COORD_WIDTH-1:0] low_y,
    input  logic signed [COORD_WIDTH-1:0] low_z,
    input  logic signed [COORD_WIDTH-1:0] high_x,
    input  logic signed [COORD_WIDTH-1:0] high_y,
    input  logic signed [COORD_WIDTH-1:0] high_z,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [KIND_WIDTH-1:0]         out_kind,
    output logic signed [COORD_WIDTH-1:0] new_low_x,
    output logic signed [COORD_WIDTH-1:0] new_low_y,
    output logic signed [COORD_WIDTH-1:0] new_low_z,
    output logic signed [COORD_WIDTH-1:0] new_high_x,
    output logic signed [COORD_WIDTH-1:0] new_high_y,
    output logic signed [COORD_WIDTH-1:0] new_high_z
);

    localparam int ROW_WIDTH = 3 * COEF_WIDTH;
    localparam int SUM_WIDTH = COORD_WIDTH + 1;               // lo+hi, hi-lo
    localparam int MAG_WIDTH = COEF_WIDTH + 1;                // |coef|, signed
    localparam int PA_WIDTH  = SUM_WIDTH + COEF_WIDTH;
    localparam int PB_WIDTH  = SUM_WIDTH + MAG_WIDTH;
    localparam int ACC_WIDTH = PB_WIDTH + 3;
    localparam int FRAC      = COEF_WIDTH - 1;
    localparam int Q_WIDTH   = ACC_WIDTH - FRAC;

    localparam logic [ROW_WIDTH-1:0] ONE_COEF = ROW_WIDTH'(1) << (COEF_WIDTH - 2);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;
    typedef logic signed [PA_WIDTH-1:0]    prod_a_t;
    typedef logic signed [PB_WIDTH-1:0]    prod_b_t;
    typedef logic signed [ACC_WIDTH-1:0]   acc_t;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [ROW_WIDTH-1:0]     row_reg [3];
    coord_t                   trans_reg [3];
    logic [REG_IDX_WIDTH-1:0] reg_idx;
    logic                     cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[REG_IDX_LSB +: REG_IDX_WIDTH];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0]   <= ONE_COEF;
            row_reg[1]   <= ONE_COEF << COEF_WIDTH;
            row_reg[2]   <= ONE_COEF << (2 * COEF_WIDTH);
            trans_reg[0] <= '0;
            trans_reg[1] <= '0;
            trans_reg[2] <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_ROW0:    row_reg[0]   <= pwdata[ROW_WIDTH-1:0];
                REG_ROW1:    row_reg[1]   <= pwdata[ROW_WIDTH-1:0];
                REG_ROW2:    row_reg[2]   <= pwdata[ROW_WIDTH-1:0];
                REG_TRANS_X: trans_reg[0] <= pwdata[COORD_WIDTH-1:0];
                REG_TRANS_Y: trans_reg[1] <= pwdata[COORD_WIDTH-1:0];
                REG_TRANS_Z: trans_reg[2] <= pwdata[COORD_WIDTH-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ROW0:    prdata = APB_DATA_WIDTH'(row_reg[0]);
            REG_ROW1:    prdata = APB_DATA_WIDTH'(row_reg[1]);
            REG_ROW2:    prdata = APB_DATA_WIDTH'(row_reg[2]);
            REG_TRANS_X: prdata = APB_DATA_WIDTH'(unsigned'(trans_reg[0]));
            REG_TRANS_Y: prdata = APB_DATA_WIDTH'(unsigned'(trans_reg[1]));
            REG_TRANS_Z: prdata = APB_DATA_WIDTH'(unsigned'(trans_reg[2]));
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Pipeline handshake: each stage moves when the one after it has room
    // ------------------------------------------------------------------------
    logic v1_reg, v2_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3     = !out_valid_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                out_valid_reg <= v2_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: corner sum and difference
    // ------------------------------------------------------------------------
    coord_t               lo_in [3];
    coord_t               hi_in [3];
    logic [KIND_WIDTH-1:0] kind1_reg;
    coord_t               lo1_reg [3];
    coord_t               hi1_reg [3];
    sum_t                 s1_reg [3];
    sum_t                 d1_reg [3];

    assign lo_in[0] = low_x;
    assign lo_in[1] = low_y;
    assign lo_in[2] = low_z;
    assign hi_in[0] = high_x;
    assign hi_in[1] = high_y;
    assign hi_in[2] = high_z;

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy1)
        begin
            kind1_reg <= extent_kind;
            for (int k = 0; k < 3; k++)
            begin
                lo1_reg[k] <= lo_in[k];
                hi1_reg[k] <= hi_in[k];
                s1_reg[k]  <= SUM_WIDTH'(lo_in[k]) + SUM_WIDTH'(hi_in[k]);
                d1_reg[k]  <= SUM_WIDTH'(hi_in[k]) - SUM_WIDTH'(lo_in[k]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: products, M*(2c) and |M|*(2h)
    // ------------------------------------------------------------------------
    logic signed [COEF_WIDTH-1:0] coef [3][3];
    logic signed [MAG_WIDTH-1:0]  mag  [3][3];
    logic [KIND_WIDTH-1:0]        kind2_reg;
    coord_t                       lo2_reg [3];
    coord_t                       hi2_reg [3];
    prod_a_t                      pa2_reg [3][3];
    prod_b_t                      pb2_reg [3][3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                coef[r][k] = row_reg[r][k*COEF_WIDTH +: COEF_WIDTH];
                mag[r][k]  = coef[r][k][COEF_WIDTH-1] ? -MAG_WIDTH'(coef[r][k])
                                                      :  MAG_WIDTH'(coef[r][k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg && rdy2)
        begin
            kind2_reg <= kind1_reg;
            for (int k = 0; k < 3; k++)
            begin
                lo2_reg[k] <= lo1_reg[k];
                hi2_reg[k] <= hi1_reg[k];
            end
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pa2_reg[r][k] <= PA_WIDTH'(coef[r][k]) * PA_WIDTH'(s1_reg[k]);
                    pb2_reg[r][k] <= PB_WIDTH'(mag[r][k]) * PB_WIDTH'(d1_reg[k]);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: accumulate, round half up, rescale, saturate
    // ------------------------------------------------------------------------
    function automatic coord_t round_sat(input acc_t v);
        logic [Q_WIDTH-1:0] q;
        logic [Q_WIDTH-COORD_WIDTH:0] top;
        coord_t res;
        q   = v[ACC_WIDTH-1:FRAC];
        top = q[Q_WIDTH-1:COORD_WIDTH-1];
        if (top == '0 || top == '1)
            res = q[COORD_WIDTH-1:0];
        else if (q[Q_WIDTH-1])
            res = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        else
            res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        return res;
    endfunction

    acc_t   ctr_acc [3];
    acc_t   half_acc [3];
    coord_t low_next [3];
    coord_t high_next [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            ctr_acc[r]  = (ACC_WIDTH'(trans_reg[r]) <<< FRAC)
                        + (ACC_WIDTH'(1) << (FRAC - 1));
            half_acc[r] = '0;
            for (int k = 0; k < 3; k++)
            begin
                ctr_acc[r]  = ctr_acc[r] + ACC_WIDTH'(pa2_reg[r][k]);
                half_acc[r] = half_acc[r] + ACC_WIDTH'(pb2_reg[r][k]);
            end
            if (kind2_reg == KIND_FINITE)
            begin
                low_next[r]  = round_sat(ctr_acc[r] - half_acc[r]);
                high_next[r] = round_sat(ctr_acc[r] + half_acc[r]);
            end
            else
            begin
                low_next[r]  = lo2_reg[r];
                high_next[r] = hi2_reg[r];
            end
        end
    end

    logic [KIND_WIDTH-1:0] out_kind_reg;
    coord_t                out_low_reg [3];
    coord_t                out_high_reg [3];

    always_ff @(posedge clk)
    begin
        if (v2_reg && rdy3)
        begin
            out_kind_reg <= kind2_reg;
            for (int r = 0; r < 3; r++)
            begin
                out_low_reg[r]  <= low_next[r];
                out_high_reg[r] <= high_next[r];
            end
        end
    end

    assign out_kind   = out_kind_reg;
    assign new_low_x  = out_low_reg[0];
    assign new_low_y  = out_low_reg[1];
    assign new_low_z  = out_low_reg[2];
    assign new_high_x = out_high_reg[0];
    assign new_high_y = out_high_reg[1];
    assign new_high_z = out_high_reg[2];

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v1_reg)
        else $error("accepted item missing from input stage");

    a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !rdy2) |=> (v1_reg && $stable(kind1_reg)))
        else $error("stalled input stage lost its item");

    a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && rdy3 && kind2_reg != KIND_FINITE)
        |=> (new_low_x == $past(lo2_reg[0]) && new_high_z == $past(hi2_reg[2])))
        else $error("non-finite box corners altered");

    a_kind_carried: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && rdy3) |=> (out_valid && out_kind == $past(kind2_reg)))
        else $error("result kind does not follow its item");

endmodule

>>> dv/aabb_transform_checker.sv
// ----------------------------------------------------------------------------
// aabb_transform_checker
// Watches the register port and both box channels of the affine box
// transform, predicts each transformed box from its own copy of the matrix
// and translation, and compares every result field against the oldest
// pending prediction. Hands its error count and in-flight depth to the top.
// ----------------------------------------------------------------------------
module aabb_transform_checker
    import aat_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    input  logic                      pready,

    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [KIND_WIDTH-1:0]     extent_kind,
    input  logic [COORD_WIDTH_DEF-1:0] low_x,
    input  logic [COORD_WIDTH_DEF-1:0] low_y,
    input  logic [COORD_WIDTH_DEF-1:0] low_z,
    input  logic [COORD_WIDTH_DEF-1:0] high_x,
    input  logic [COORD_WIDTH_DEF-1:0] high_y,
    input  logic [COORD_WIDTH_DEF-1:0] high_z,

    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [KIND_WIDTH-1:0]     out_kind,
    input  logic [COORD_WIDTH_DEF-1:0] new_low_x,
    input  logic [COORD_WIDTH_DEF-1:0] new_low_y,
    input  logic [COORD_WIDTH_DEF-1:0] new_low_z,
    input  logic [COORD_WIDTH_DEF-1:0] new_high_x,
    input  logic [COORD_WIDTH_DEF-1:0] new_high_y,
    input  logic [COORD_WIDTH_DEF-1:0] new_high_z,

    output int                        mismatch_count,
    output int                        boxes_in_flight
);

    localparam int CW     = COORD_WIDTH_DEF;
    localparam int COEF_W = COEF_WIDTH_DEF;
    localparam int FRAC   = COEF_W - 1;

    localparam logic [COEF_W-1:0] ONE_COEF = COEF_W'(1) << (COEF_W - 2);
    localparam longint SAT_MAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint SAT_MIN = -SAT_MAX - 1;

    // corner[0..2] = low x/y/z, corner[3..5] = high x/y/z
    typedef struct packed {
        logic [KIND_WIDTH-1:0] kind;
        logic [5:0][CW-1:0]    corner;
    } box_t;

    string corner_name [6] = '{"low_x", "low_y", "low_z", "high_x", "high_y", "high_z"};

    logic [3*COEF_W-1:0]  row_coef  [3];
    logic signed [CW-1:0] shift_vec [3];
    box_t                 pending [$];
    int                   result_idx;

    // acc is at scale 2^FRAC; round half up, then clamp to the coordinate range
    function automatic logic [CW-1:0] round_sat(input longint acc);
        longint q;
        q = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        if (q > SAT_MAX)
            q = SAT_MAX;
        else if (q < SAT_MIN)
            q = SAT_MIN;
        return q[CW-1:0];
    endfunction

    function automatic box_t transform_box(input box_t b);
        box_t                 r;
        longint               sum_v  [3];
        longint               diff_v [3];
        longint               center_acc;
        longint               spread_acc;
        longint               coef;
        longint               shift_t;
        logic signed [COEF_W-1:0] cf;
        logic signed [CW-1:0] lo_c;
        logic signed [CW-1:0] hi_c;
        r = b;
        if (b.kind != KIND_FINITE)
            return r;
        for (int k = 0; k < 3; k++)
        begin
            lo_c      = b.corner[k];
            hi_c      = b.corner[k+3];
            sum_v[k]  = longint'(lo_c) + longint'(hi_c);
            diff_v[k] = longint'(hi_c) - longint'(lo_c);
        end
        // sum = 2*center, diff = 2*half; Q2.14 times 2x gives scale 2^15
        for (int ri = 0; ri < 3; ri++)
        begin
            center_acc = 0;
            spread_acc = 0;
            for (int k = 0; k < 3; k++)
            begin
                cf         = row_coef[ri][k*COEF_W +: COEF_W];
                coef       = cf;
                center_acc += coef * sum_v[k];
                spread_acc += (coef < 0 ? -coef : coef) * diff_v[k];
            end
            shift_t          = longint'(shift_vec[ri]) <<< FRAC;
            r.corner[ri]     = round_sat(center_acc - spread_acc + shift_t);
            r.corner[ri + 3] = round_sat(center_acc + spread_acc + shift_t);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        box_t got;
        box_t want;
        box_t seen;
        if (!rst_n)
        begin
            pending.delete();
            mismatch_count  = 0;
            boxes_in_flight = 0;
            result_idx      = 0;
            for (int i = 0; i < 3; i++)
            begin
                row_coef[i]                      = '0;
                row_coef[i][i*COEF_W +: COEF_W]  = ONE_COEF;
                shift_vec[i]                     = '0;
            end
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[REG_IDX_LSB +: REG_IDX_WIDTH])
                    REG_ROW0:    row_coef[0]  = pwdata[3*COEF_W-1:0];
                    REG_ROW1:    row_coef[1]  = pwdata[3*COEF_W-1:0];
                    REG_ROW2:    row_coef[2]  = pwdata[3*COEF_W-1:0];
                    REG_TRANS_X: shift_vec[0] = pwdata[CW-1:0];
                    REG_TRANS_Y: shift_vec[1] = pwdata[CW-1:0];
                    REG_TRANS_Z: shift_vec[2] = pwdata[CW-1:0];
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                got.kind   = out_kind;
                got.corner = {new_high_z, new_high_y, new_high_x,
                              new_low_z, new_low_y, new_low_x};
                if (pending.size() == 0)
                begin
                    $display("%0t: result %0d arrived with no box pending", $time, result_idx);
                    mismatch_count++;
                end
                else
                begin
                    want = pending.pop_front();
                    if (got.kind !== want.kind)
                    begin
                        $display("%0t: result %0d kind: expected %0d, got %0d",
                                 $time, result_idx, want.kind, got.kind);
                        mismatch_count++;
                    end
                    for (int i = 0; i < 6; i++)
                    begin
                        if (got.corner[i] !== want.corner[i])
                        begin
                            $display("%0t: result %0d %s: expected %0d, got %0d", $time,
                                     result_idx, corner_name[i],
                                     $signed(want.corner[i]), $signed(got.corner[i]));
                            mismatch_count++;
                        end
                    end
                end
                result_idx++;
            end

            if (in_valid && in_ready)
            begin
                seen.kind   = extent_kind;
                seen.corner = {high_z, high_y, high_x, low_z, low_y, low_x};
                pending.push_back(transform_box(seen));
            end
            boxes_in_flight = pending.size();
        end
    end

endmodule

>>> dv/aabb_affine_transform_tb.sv
// ----------------------------------------------------------------------------
// aabb_affine_transform_tb
// Drives boxes through the affine box transform: directed corner cases
// under the reset matrix and an extreme one, then bursts of random boxes
// over a range of matrix and translation settings, with random gaps, output
// stalls and one long output hold. The checker beside the block compares.
// ----------------------------------------------------------------------------
module aabb_affine_transform_tb;
    import aat_pkg::*;

    localparam int CW          = COORD_WIDTH_DEF;
    localparam int COEF_W      = COEF_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;
    localparam int PHASE_COUNT = 10;
    localparam int PHASE_BOXES = 63;
    localparam int MID_SPAN    = 1 << 22;
    localparam int TINY_SPAN   = 1024;

    localparam logic [KIND_WIDTH-1:0]    KIND_UNUSED  = 2'd3;
    localparam logic [REG_IDX_WIDTH-1:0] REG_UNUSED_A = 3'd6;
    localparam logic [REG_IDX_WIDTH-1:0] REG_UNUSED_B = 3'd7;

    localparam logic signed [CW-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [CW-1:0] C_MAX = 32'sh7FFF_FFFF;

    typedef enum int {
        CFG_RANDOM,
        CFG_NEAR_UNIT,
        CFG_MOST_NEG,
        CFG_MOST_POS,
        CFG_ZERO,
        CFG_ALL_ONES
    } cfg_mode_t;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      psel        = 1'b0;
    logic                      penable     = 1'b0;
    logic                      pwrite      = 1'b0;
    logic [APB_ADDR_WIDTH-1:0] paddr       = '0;
    logic [APB_DATA_WIDTH-1:0] pwdata      = '0;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;
    logic                      in_valid    = 1'b0;
    logic                      in_ready;
    logic [KIND_WIDTH-1:0]     extent_kind = KIND_NULL;
    logic signed [CW-1:0]      low_x       = '0;
    logic signed [CW-1:0]      low_y       = '0;
    logic signed [CW-1:0]      low_z       = '0;
    logic signed [CW-1:0]      high_x      = '0;
    logic signed [CW-1:0]      high_y      = '0;
    logic signed [CW-1:0]      high_z      = '0;
    logic                      out_valid;
    logic                      out_ready   = 1'b0;
    logic [KIND_WIDTH-1:0]     out_kind;
    logic signed [CW-1:0]      new_low_x;
    logic signed [CW-1:0]      new_low_y;
    logic signed [CW-1:0]      new_low_z;
    logic signed [CW-1:0]      new_high_x;
    logic signed [CW-1:0]      new_high_y;
    logic signed [CW-1:0]      new_high_z;

    int mismatch_count;
    int boxes_in_flight;
    int boxes_sent  = 0;
    int cycle_count = 0;

    aabb_affine_transform u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .extent_kind(extent_kind),
        .low_x      (low_x),
        .low_y      (low_y),
        .low_z      (low_z),
        .high_x     (high_x),
        .high_y     (high_y),
        .high_z     (high_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_kind   (out_kind),
        .new_low_x  (new_low_x),
        .new_low_y  (new_low_y),
        .new_low_z  (new_low_z),
        .new_high_x (new_high_x),
        .new_high_y (new_high_y),
        .new_high_z (new_high_z)
    );

    aabb_transform_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .extent_kind    (extent_kind),
        .low_x          (low_x),
        .low_y          (low_y),
        .low_z          (low_z),
        .high_x         (high_x),
        .high_y         (high_y),
        .high_z         (high_z),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_kind       (out_kind),
        .new_low_x      (new_low_x),
        .new_low_y      (new_low_y),
        .new_low_z      (new_low_z),
        .new_high_x     (new_high_x),
        .new_high_y     (new_high_y),
        .new_high_z     (new_high_z),
        .mismatch_count (mismatch_count),
        .boxes_in_flight(boxes_in_flight)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[aabb_affine_transform] ERROR");
            $finish;
        end
    end

    // output side: randomly chosen stall patterns, plus
    // one long hold so the pipeline fills and backs up into the input
    initial
    begin : sink
        int  hold      = 0;
        int  mode_left = 0;
        int  mode      = 0;
        int  beat      = 0;
        bit  held      = 1'b0;
        forever
        begin
            @(posedge clk);
            beat++;
            // mid-phase, so the sender keeps offering items during the hold
            if (!held && boxes_sent >= 180)
            begin
                held = 1'b1;
                hold = 120;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= (beat % 3 != 0);
                endcase
            end
        end
    end

    function automatic logic signed [CW-1:0] rand_coord(input int span);
        case (span)
            0:       return $urandom;
            1:       return int'($urandom_range(0, 2 * MID_SPAN)) - MID_SPAN;
            default: return int'($urandom_range(0, 2 * TINY_SPAN)) - TINY_SPAN;
        endcase
    endfunction

    function automatic logic [63:0] pack_row(input logic [COEF_W-1:0] c0,
                                             input logic [COEF_W-1:0] c1,
                                             input logic [COEF_W-1:0] c2);
        return {16'h0, c2, c1, c0};
    endfunction

    task automatic apb_write(input logic [REG_IDX_WIDTH-1:0] idx,
                             input logic [APB_DATA_WIDTH-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_WIDTH'(idx) << REG_IDX_LSB;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic load_transform(input cfg_mode_t mode);
        logic [63:0] rows  [3];
        logic [63:0] shift [3];
        for (int r = 0; r < 3; r++)
        begin
            case (mode)
                CFG_RANDOM:
                begin
                    rows[r]  = {$urandom, $urandom};
                    shift[r] = {$urandom, $urandom};
                end
                CFG_NEAR_UNIT:
                begin
                    rows[r]  = pack_row(COEF_W'(int'($urandom_range(0, 32768)) - 16384),
                                        COEF_W'(int'($urandom_range(0, 32768)) - 16384),
                                        COEF_W'(int'($urandom_range(0, 32768)) - 16384));
                    shift[r] = {32'h0, rand_coord(1)};
                end
                CFG_MOST_NEG:
                begin
                    rows[r]  = pack_row(16'h8000, 16'h8000, 16'h8000);
                    shift[r] = {32'h0, C_MAX};
                end
                CFG_MOST_POS:
                begin
                    rows[r]  = pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF);
                    shift[r] = {32'hFFFF_FFFF, C_MIN};
                end
                CFG_ZERO:
                begin
                    rows[r]  = '0;
                    shift[r] = '0;
                end
                default:
                begin
                    rows[r]  = '1;
                    shift[r] = '1;
                end
            endcase
        end
        apb_write(REG_ROW0, rows[0]);
        apb_write(REG_ROW1, rows[1]);
        apb_write(REG_ROW2, rows[2]);
        apb_write(REG_TRANS_X, shift[0]);
        apb_write(REG_TRANS_Y, shift[1]);
        apb_write(REG_TRANS_Z, shift[2]);
        // unmapped slots must not disturb anything
        if (mode == CFG_RANDOM)
        begin
            apb_write(REG_UNUSED_A, {$urandom, $urandom});
            apb_write(REG_UNUSED_B, {$urandom, $urandom});
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_box(input logic [KIND_WIDTH-1:0] k,
                            input logic signed [CW-1:0] lx, input logic signed [CW-1:0] ly,
                            input logic signed [CW-1:0] lz, input logic signed [CW-1:0] hx,
                            input logic signed [CW-1:0] hy, input logic signed [CW-1:0] hz);
        in_valid    <= 1'b1;
        extent_kind <= k;
        low_x       <= lx;
        low_y       <= ly;
        low_z       <= lz;
        high_x      <= hx;
        high_y      <= hy;
        high_z      <= hz;
        do @(posedge clk); while (!in_ready);
        boxes_sent++;
    endtask

    task automatic send_random_box();
        logic signed [CW-1:0] lo_v [3];
        logic signed [CW-1:0] hi_v [3];
        logic signed [CW-1:0] tmp;
        logic [KIND_WIDTH-1:0] k;
        int span;
        k = KIND_FINITE;
        if ($urandom_range(0, 9) >= 8)
        begin
            case ($urandom_range(0, 2))
                0:       k = KIND_NULL;
                1:       k = KIND_INFINITE;
                default: k = KIND_UNUSED;
            endcase
        end
        span = $urandom_range(0, 2);
        for (int a = 0; a < 3; a++)
        begin
            lo_v[a] = rand_coord(span);
            hi_v[a] = rand_coord(span);
            // mostly well-ordered boxes; the rest stay inverted
            if (lo_v[a] > hi_v[a] && $urandom_range(0, 9) != 0)
            begin
                tmp     = lo_v[a];
                lo_v[a] = hi_v[a];
                hi_v[a] = tmp;
            end
        end
        send_box(k, lo_v[0], lo_v[1], lo_v[2], hi_v[0], hi_v[1], hi_v[2]);
    endtask

    task automatic run_directed();
        send_box(KIND_NULL, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        send_box(KIND_INFINITE, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
        send_box(KIND_UNUSED, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555);
        send_box(KIND_FINITE, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        send_box(KIND_FINITE, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
        send_box(KIND_FINITE, 0, 0, 0, 0, 0, 0);
        send_box(KIND_FINITE, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        send_box(KIND_FINITE, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
        // half-LSB center: exercises the round-half-up tie
        send_box(KIND_FINITE, -1, -1, -1, 0, 0, 0);
        send_box(KIND_FINITE, -3, 5, -7, 2, 6, 1);
        send_box(KIND_FINITE, -65536, -65536, -65536, 65536, 65536, 65536);
        send_box(KIND_FINITE, 0, 0, 0, 1, 1, 1);
        in_valid <= 1'b0;
    endtask

    task automatic run_phase(input int count);
        int left;
        int burst;
        int gap;
        bit steady;
        steady = ($urandom_range(0, 3) == 0);
        left   = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            repeat (burst) send_random_box();
            left -= burst;
            gap = steady ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        @(posedge clk);
        while (boxes_in_flight != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain();
        load_transform(CFG_MOST_NEG);
        run_directed();
        drain();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            load_transform(cfg_mode_t'(p % 6));
            run_phase(PHASE_BOXES);
            drain();
        end

        if (mismatch_count == 0)
            $display("[aabb_affine_transform] OK");
        else
            $display("[aabb_affine_transform] ERROR");
        $finish;
    end

endmodule
